// File: sv/http_byte_range_parser_macros.svh
// Assertion helpers for the byte-range parser.
// Both macros assume a clock named clk and an active-low reset named arst_n.
`ifndef HTTP_BYTE_RANGE_PARSER_MACROS_SVH
`define HTTP_BYTE_RANGE_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define HBR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define HBR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define HBR_ASSERT_IMPL(label, ante, cons)
`define HBR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: sv/hbr_pkg.sv
package hbr_pkg;

	// Snapshot of the parse taken on the last byte of a header
	typedef struct packed {
		logic        is_suffix;   // suffix form with at least one digit
		logic        is_range;    // START- or START-END form
		logic        digit_seen;
		logic [63:0] num;
		logic [63:0] start;
	} parse_res_t;

	localparam logic [2:0] PREFIX_LEN  = 3'd6;
	localparam logic [7:0] CH_DASH     = 8'h2D;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;
	localparam logic [63:0] U64_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;

	// "bytes=" one character at a time
	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h62;
			3'd1: c = 8'h79;
			3'd2: c = 8'h74;
			3'd3: c = 8'h65;
			3'd4: c = 8'h73;
			3'd5: c = 8'h3D;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// acc*10 + d, saturating at 2^64-1; the carry-out bits flag overflow
	function automatic logic [63:0] sat_acc(input logic [63:0] acc, input logic [3:0] d);
		logic [67:0] t;
		t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {64'd0, d};
		return (|t[67:64]) ? U64_MAX : t[63:0];
	endfunction

endpackage

// File: sv/hbr_byte_if.sv
interface hbr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;
	logic       last_byte_flag;

	modport source (output valid, output header_byte, output last_byte_flag, input ready);
	modport sink   (input valid, input header_byte, input last_byte_flag, output ready);
endinterface

// File: sv/hbr_range_if.sv
interface hbr_range_if;
	logic        valid;
	logic        ready;
	logic        range_valid;
	logic [63:0] range_first;
	logic [63:0] range_last;
	logic [63:0] range_total;

	modport source (output valid, output range_valid, output range_first,
		output range_last, output range_total, input ready);
	modport sink   (input valid, input range_valid, input range_first,
		input range_last, input range_total, output ready);
endinterface

// File: sv/http_byte_range_parser.sv
// A result is offered once the header's last byte has passed the input register, the
// parse snapshot register and then the result register.
// Throughput: one header byte per cycle while the result path has room (a last byte waits
// for it); the parse state update (multiply by ten, add a digit, saturate) sets that rate.
// Reset (arst_n low, asynchronous): parse state, the size register and all valid flags clear.
`include "http_byte_range_parser_macros.svh"

module http_byte_range_parser (
	input  logic        clk,
	input  logic        arst_n,
	hbr_byte_if.sink    byte_in,
	hbr_range_if.source range_out,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);

	logic [63:0] rsrc_size_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic                valid_s2;
	hbr_pkg::parse_res_t res_s2;
	hbr_pkg::parse_res_t res;

	logic        out_valid_q;
	logic        out_ok_q;
	logic [63:0] out_first_q;
	logic [63:0] out_last_q;
	logic [63:0] out_total_q;

	logic out_free, s2_free, proc_s1, s1_free;

	assign out_free = !out_valid_q || range_out.ready;
	assign s2_free  = !valid_s2 || out_free;
	// a non-last byte never needs room downstream
	assign proc_s1  = valid_s1 && (!last_s1 || s2_free);
	assign s1_free  = !valid_s1 || proc_s1;
	assign byte_in.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsrc_size_q <= '0;
		end else if (cfg_we) begin
			rsrc_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && byte_in.valid) begin
			byte_s1 <= byte_in.header_byte;
			last_s1 <= byte_in.last_byte_flag;
		end
	end

	hbr_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (proc_s1),
		.hdr_byte (byte_s1),
		.last     (last_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= proc_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && proc_s1 && last_s1) res_s2 <= res;
	end

	// judge the parsed form against the file size
	logic [63:0] fs_m1, suf_len, suf_first, rng_last;
	logic        fs_nz, ok_suf, ok_rng, ok;
	logic [63:0] first_j, last_j;

	always_comb begin
		fs_nz     = rsrc_size_q != '0;
		fs_m1     = rsrc_size_q - 64'd1;
		// suffix of zero or past the end selects the whole file
		suf_len   = (res_s2.num == '0 || res_s2.num > rsrc_size_q) ? rsrc_size_q : res_s2.num;
		suf_first = rsrc_size_q - suf_len;
		rng_last  = (res_s2.digit_seen && res_s2.num < fs_m1) ? res_s2.num : fs_m1;
		ok_suf    = fs_nz && res_s2.is_suffix;
		ok_rng    = fs_nz && res_s2.is_range && res_s2.start < rsrc_size_q
			&& res_s2.start <= rng_last;
		ok        = ok_suf || ok_rng;
		first_j   = ok_suf ? suf_first : (ok_rng ? res_s2.start : '0);
		last_j    = ok ? (ok_suf ? fs_m1 : rng_last) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			out_ok_q    <= ok;
			out_first_q <= first_j;
			out_last_q  <= last_j;
			out_total_q <= rsrc_size_q;
		end
	end

	assign range_out.valid       = out_valid_q;
	assign range_out.range_valid = out_ok_q;
	assign range_out.range_first = out_first_q;
	assign range_out.range_last  = out_last_q;
	assign range_out.range_total = out_total_q;

	`HBR_ASSERT_IMPL(a_ok_ordered, range_out.valid && range_out.range_valid,
		range_out.range_first <= range_out.range_last
		&& range_out.range_last < range_out.range_total)
	`HBR_ASSERT_IMPL(a_bad_zero, range_out.valid && !range_out.range_valid,
		range_out.range_first == '0 && range_out.range_last == '0)
	`HBR_ASSERT_NEXT(a_in_captured, byte_in.valid && byte_in.ready, valid_s1)
	`HBR_ASSERT_NEXT(a_snap_only_last, proc_s1 && !last_s1 && s2_free, !valid_s2)

endmodule

// File: sv/hbr_parse.sv
module hbr_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        hdr_byte,
	input  logic              last,
	output hbr_pkg::parse_res_t res
);

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_FIRST,
		PH_SUFFIX,
		PH_START,
		PH_END,
		PH_TAIL_SUFFIX,
		PH_TAIL_RANGE,
		PH_FAIL
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [2:0]  pos_q, pos_n;
	logic [63:0] acc_q, acc_n;
	logic [63:0] start_q, start_n;
	logic        seen_q, seen_n;

	logic [7:0] lc;
	logic       is_dig;
	logic [3:0] dig;

	assign lc = (hdr_byte >= hbr_pkg::CH_UPPER_A && hdr_byte <= hbr_pkg::CH_UPPER_Z) ?
		hdr_byte + hbr_pkg::CASE_OFFSET : hdr_byte;
	assign is_dig = hdr_byte >= hbr_pkg::CH_ZERO && hdr_byte <= hbr_pkg::CH_NINE;
	// ASCII digits sit at 0x30, so the low nibble is the value
	assign dig = hdr_byte[3:0];

	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		acc_n   = acc_q;
		start_n = start_q;
		seen_n  = seen_q;
		unique case (phase_q)
			PH_PREFIX: begin
				if (lc == hbr_pkg::prefix_char(pos_q)) begin
					pos_n = pos_q + 3'd1;
					if (pos_n >= hbr_pkg::PREFIX_LEN) phase_n = PH_FIRST;
				end else begin
					phase_n = PH_FAIL;
				end
			end
			PH_FIRST: begin
				if (hdr_byte == hbr_pkg::CH_DASH) begin
					phase_n = PH_SUFFIX;
					acc_n   = '0;
					seen_n  = 1'b0;
				end else if (is_dig) begin
					phase_n = PH_START;
					acc_n   = {60'd0, dig};
					seen_n  = 1'b1;
				end else begin
					phase_n = PH_FAIL;
				end
			end
			PH_SUFFIX: begin
				if (is_dig) begin
					acc_n  = hbr_pkg::sat_acc(acc_q, dig);
					seen_n = 1'b1;
				end else begin
					phase_n = seen_q ? PH_TAIL_SUFFIX : PH_FAIL;
				end
			end
			PH_START: begin
				if (is_dig) begin
					acc_n = hbr_pkg::sat_acc(acc_q, dig);
				end else if (hdr_byte == hbr_pkg::CH_DASH) begin
					start_n = acc_q;
					acc_n   = '0;
					seen_n  = 1'b0;
					phase_n = PH_END;
				end else begin
					phase_n = PH_FAIL;
				end
			end
			PH_END: begin
				if (is_dig) begin
					acc_n  = hbr_pkg::sat_acc(acc_q, dig);
					seen_n = 1'b1;
				end else begin
					phase_n = PH_TAIL_RANGE;
				end
			end
			PH_TAIL_SUFFIX, PH_TAIL_RANGE, PH_FAIL: begin
			end
		endcase
	end

	always_comb begin
		res.is_suffix  = (phase_n == PH_SUFFIX || phase_n == PH_TAIL_SUFFIX) && seen_n;
		res.is_range   = phase_n == PH_END || phase_n == PH_TAIL_RANGE;
		res.digit_seen = seen_n;
		res.num        = acc_n;
		res.start      = start_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			pos_q   <= '0;
			acc_q   <= '0;
			start_q <= '0;
			seen_q  <= 1'b0;
		end else if (take) begin
			if (last) begin
				// header done: start over for the next one
				phase_q <= PH_PREFIX;
				pos_q   <= '0;
				acc_q   <= '0;
				start_q <= '0;
				seen_q  <= 1'b0;
			end else begin
				phase_q <= phase_n;
				pos_q   <= pos_n;
				acc_q   <= acc_n;
				start_q <= start_n;
				seen_q  <= seen_n;
			end
		end
	end

endmodule

// File: test/testbench.sv
module testbench;

	localparam int          LIMIT        = 300000;
	localparam int          DRAIN_CYCLES = 10;
	localparam int          HOLD_CYCLES  = 300;
	localparam logic [47:0] PREFIX_STR   = "bytes=";

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_FIRST,
		PH_SUFFIX,
		PH_START,
		PH_END,
		PH_TAIL_SUFFIX,
		PH_TAIL_RANGE,
		PH_FAIL
	} phase_t;

	typedef struct {
		logic        ok;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] total;
	} byte_range_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [63:0] cfg_wdata;

	hbr_byte_if  byte_if ();
	hbr_range_if range_if ();

	http_byte_range_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_if),
		.range_out (range_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow parse state
	phase_t      ph;
	int          matched;
	logic [63:0] acc;
	logic [63:0] start_num;
	logic        have_digit;
	logic [63:0] size_shadow;

	byte_range_t ranges_due[$];
	int          errors = 0;
	int          cycles = 0;
	int          bytes_sent = 0;
	int          hold_asks = 0;
	bit          src_idle = 1'b1;
	bit          sink_idle = 1'b1;

	function automatic logic [63:0] push_digit(input logic [63:0] a, input logic [7:0] ch);
		logic [63:0] d;
		d = {56'd0, ch - hbr_pkg::CH_ZERO};
		if (a > hbr_pkg::U64_MAX / 64'd10)
			return hbr_pkg::U64_MAX;
		a = a * 64'd10;
		if (a > hbr_pkg::U64_MAX - d)
			return hbr_pkg::U64_MAX;
		return a + d;
	endfunction

	function automatic bit is_num(input logic [7:0] ch);
		return ch >= hbr_pkg::CH_ZERO && ch <= hbr_pkg::CH_NINE;
	endfunction

	task automatic reset_parse();
		ph = PH_PREFIX;
		matched = 0;
		acc = '0;
		start_num = '0;
		have_digit = 1'b0;
	endtask

	task automatic parse_char(input logic [7:0] ch);
		logic [7:0] lc;
		lc = (ch >= hbr_pkg::CH_UPPER_A && ch <= hbr_pkg::CH_UPPER_Z) ?
			ch + hbr_pkg::CASE_OFFSET : ch;
		case (ph)
			PH_PREFIX: begin
				if (lc == PREFIX_STR[47 - 8 * matched -: 8]) begin
					matched++;
					if (matched >= 6)
						ph = PH_FIRST;
				end else begin
					ph = PH_FAIL;
				end
			end
			PH_FIRST: begin
				if (ch == hbr_pkg::CH_DASH) begin
					ph = PH_SUFFIX;
					acc = '0;
					have_digit = 1'b0;
				end else if (is_num(ch)) begin
					ph = PH_START;
					acc = {56'd0, ch - hbr_pkg::CH_ZERO};
					have_digit = 1'b1;
				end else begin
					ph = PH_FAIL;
				end
			end
			PH_SUFFIX: begin
				if (is_num(ch)) begin
					acc = push_digit(acc, ch);
					have_digit = 1'b1;
				end else begin
					ph = have_digit ? PH_TAIL_SUFFIX : PH_FAIL;
				end
			end
			PH_START: begin
				if (is_num(ch)) begin
					acc = push_digit(acc, ch);
				end else if (ch == hbr_pkg::CH_DASH) begin
					start_num = acc;
					acc = '0;
					have_digit = 1'b0;
					ph = PH_END;
				end else begin
					ph = PH_FAIL;
				end
			end
			PH_END: begin
				if (is_num(ch)) begin
					acc = push_digit(acc, ch);
					have_digit = 1'b1;
				end else begin
					ph = PH_TAIL_RANGE;
				end
			end
			default: ;
		endcase
	endtask

	function automatic byte_range_t judge_header();
		byte_range_t r;
		logic [63:0] s;
		r.ok = 1'b0;
		r.lo = '0;
		r.hi = '0;
		r.total = size_shadow;
		if (size_shadow != 0) begin
			if ((ph == PH_SUFFIX || ph == PH_TAIL_SUFFIX) && have_digit) begin
				// zero or oversized suffix means the whole file
				s = (acc == 0 || acc > size_shadow) ? size_shadow : acc;
				r.lo = size_shadow - s;
				r.hi = size_shadow - 64'd1;
				r.ok = 1'b1;
			end else if (ph == PH_END || ph == PH_TAIL_RANGE) begin
				r.lo = start_num;
				r.hi = size_shadow - 64'd1;
				if (have_digit && acc < r.hi)
					r.hi = acc;
				r.ok = 1'b1;
			end
			if (r.ok && (r.lo >= size_shadow || r.lo > r.hi))
				r.ok = 1'b0;
		end
		if (!r.ok) begin
			r.lo = '0;
			r.hi = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// valid stays high across back-to-back transfers; it drops only on a gap or wait_idle
	task automatic send_byte(input logic [7:0] ch, input logic lst);
		int gap;
		gap = src_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			byte_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_if.valid          <= 1'b1;
		byte_if.header_byte    <= ch;
		byte_if.last_byte_flag <= lst;
		do @(posedge clk); while (!byte_if.ready);
		bytes_sent++;
		parse_char(ch);
		if (lst) begin
			ranges_due.push_back(judge_header());
			reset_parse();
		end
	endtask

	task automatic send_text(input string s, input bit ends = 1'b1);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], ends && i == s.len() - 1);
	endtask

	task automatic wait_idle();
		byte_if.valid <= 1'b0;
		while (ranges_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(input logic [63:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_shadow = v;
		@(posedge clk);
	endtask

	task automatic append_number(ref logic [7:0] hdr[$]);
		logic [63:0] v;
		string s;
		case ($urandom_range(0, 9))
			0: v = {$urandom, $urandom};
			1: v = hbr_pkg::U64_MAX / 64'd10;
			2: v = hbr_pkg::U64_MAX - 64'($urandom_range(0, 3));
			default: v = 64'($urandom_range(0, 1200));
		endcase
		s = $sformatf("%0d", v);
		if ($urandom_range(0, 9) == 0)
			s = {"0", s};
		if ($urandom_range(0, 19) == 0)
			s = {s, "9"};
		for (int i = 0; i < s.len(); i++)
			hdr.push_back(s[i]);
	endtask

	task automatic send_random_header();
		logic [7:0] hdr[$];
		logic [7:0] ch;
		int kind, form, cut;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			repeat ($urandom_range(1, 10)) hdr.push_back(8'($urandom_range(0, 255)));
		end else begin
			for (int i = 0; i < 6; i++) begin
				ch = PREFIX_STR[47 - 8 * i -: 8];
				if ($urandom_range(0, 1) && ch != "=")
					ch = ch - hbr_pkg::CASE_OFFSET;
				hdr.push_back(ch);
			end
			form = $urandom_range(0, 2);
			if (form == 0) begin
				hdr.push_back(hbr_pkg::CH_DASH);
				append_number(hdr);
			end else begin
				append_number(hdr);
				hdr.push_back(hbr_pkg::CH_DASH);
				if (form == 2)
					append_number(hdr);
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) hdr.push_back(8'($urandom_range(0, 255)));
			// broken: truncated or one character corrupted
			if (kind >= 88) begin
				cut = $urandom_range(0, hdr.size() - 1);
				if ($urandom_range(0, 1)) begin
					while (hdr.size() > cut + 1)
						void'(hdr.pop_back());
				end else begin
					hdr[cut] = 8'($urandom_range(0, 255));
				end
			end
		end
		foreach (hdr[i])
			send_byte(hdr[i], i == hdr.size() - 1);
	endtask

	function automatic logic [63:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return 64'd1;
			2: return hbr_pkg::U64_MAX;
			3: return {$urandom, $urandom};
			default: return 64'($urandom_range(2, 1000));
		endcase
	endfunction

	task automatic test_forms();
		set_size(64'd100);
		send_text("bytes=0-99");
		send_text("BYTES=10-");
		send_text("bytes=-30");
		send_text("bytes=-0");
		send_text("bytes=-500");
		send_text("bytes=20-10");
		send_text("bytes=100-");
		send_text("bytes=5-1000");
		send_text("ByTeS=0-9,20-30");
		send_text("bytes=-5x");
		wait_idle();
	endtask

	task automatic test_malformed();
		send_text("b");
		send_text("bytes=");
		send_text("bytes=-");
		send_text("bytes=12");
		send_text("bytes=x");
		send_text("xbytes=1-2");
		// a zero byte ends the text; the rest up to the last flag is ignored
		send_text("bytes=2-", 1'b0);
		send_byte(8'h00, 1'b0);
		send_text("5");
		send_text("by", 1'b0);
		send_byte(8'h00, 1'b0);
		send_text("tes=1-2");
		wait_idle();
	endtask

	task automatic test_saturation();
		set_size(hbr_pkg::U64_MAX);
		send_text("bytes=0-18446744073709551616");
		send_text("bytes=1844674407370955161-18446744073709551615");
		send_text("bytes=18446744073709551616-");
		send_text("bytes=-99999999999999999999");
		send_text("bytes=-1844674407370955161");
		wait_idle();
	endtask

	task automatic test_size_edges();
		set_size(64'd0);
		send_text("bytes=0-0");
		send_text("bytes=-5");
		wait_idle();
		set_size(64'd1);
		send_text("bytes=0-0");
		send_text("bytes=-1");
		send_text("bytes=1-");
		send_text("bytes=0-");
		wait_idle();
	endtask

	// receiver goes quiet while the sender keeps offering, so the block backs up
	task automatic test_backpressure();
		set_size(64'd1000);
		src_idle = 1'b0;
		hold_asks++;
		repeat (20) send_random_header();
		wait_idle();
		src_idle = 1'b1;
	endtask

	task automatic test_random();
		int mark;
		for (int p = 0; p < 9; p++) begin
			set_size(p == 0 ? 64'd500 : pick_size());
			src_idle  = (p != 3);
			sink_idle = (p != 3 && p != 6);
			mark = bytes_sent;
			while (bytes_sent - mark < 110)
				send_random_header();
			wait_idle();
		end
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	// result receiver: random stalls per transfer plus the long hold
	initial begin : sink
		int stall_left, hold_seen, gap;
		stall_left = 0;
		hold_seen = 0;
		range_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				stall_left = HOLD_CYCLES;
			end
			if (!arst_n) begin
				range_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				range_if.ready <= 1'b0;
			end else begin
				gap = (range_if.valid && range_if.ready && sink_idle) ? $urandom_range(0, 4) : 0;
				if (gap > 0) begin
					stall_left = gap - 1;
					range_if.ready <= 1'b0;
				end else begin
					range_if.ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin : check
		byte_range_t want;
		if (arst_n && range_if.valid && range_if.ready) begin
			if (ranges_due.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = ranges_due.pop_front();
				if (range_if.range_valid !== want.ok)
					report_mismatch($sformatf("range_valid got %0b want %0b",
						range_if.range_valid, want.ok));
				if (range_if.range_first !== want.lo)
					report_mismatch($sformatf("range_first got %0d want %0d",
						range_if.range_first, want.lo));
				if (range_if.range_last !== want.hi)
					report_mismatch($sformatf("range_last got %0d want %0d",
						range_if.range_last, want.hi));
				if (range_if.range_total !== want.total)
					report_mismatch($sformatf("range_total got %0d want %0d",
						range_if.range_total, want.total));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = '0;
		byte_if.valid          = 1'b0;
		byte_if.header_byte    = '0;
		byte_if.last_byte_flag = 1'b0;
		size_shadow            = '0;
		reset_parse();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_forms();
		test_malformed();
		test_saturation();
		test_size_edges();
		test_backpressure();
		test_random();
		wait_idle();

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: http_byte_range_parser.f
+incdir+sv
sv/hbr_pkg.sv
sv/hbr_byte_if.sv
sv/hbr_range_if.sv
sv/hbr_parse.sv
sv/http_byte_range_parser.sv
test/testbench.sv
